### rtl/core/tbpd_pkg.sv
package tbpd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int MAX_RESULTS = 4;

   localparam logic [7:0] START_BIN = 8'h24;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_BIN = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_BIN  = 4'b0100,
      PH_TEXT = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
      logic       empty;
   } result_type;

   typedef struct packed {
      logic [2:0]                   count;
      result_type [MAX_RESULTS-1:0] res;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] term_pat(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0: value = CHAR_CR;
         2'd1: value = CHAR_LF;
         2'd2: value = CHAR_CR;
         default: value = CHAR_LF;
      endcase
      return value;
   endfunction

endpackage

### rtl/core/text_binary_packet_deframer_unit.sv
// Splits a byte stream into binary packets (0x24, four length bytes least
// significant first, then that many payload bytes) and text packets (any other
// header byte, payload up to CR LF CR LF, one byte held back so the final one is
// flagged). One byte is accepted per cycle while the four-entry queue between
// the classifier and the output stage has room. Each byte releases zero to four
// results; the output stage sends one result per cycle from its own register while
// rsp_ready is high; the queue absorbs the results of a failed partial terminator.
// Each result passes through a queue entry and then the output register.
module text_binary_packet_deframer_unit import tbpd_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_packet_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_byte,
   output logic       rsp_empty_packet
);

   bundle_type       bundle;
   bundle_type       head;
   queue_status_type q_status;
   logic             accept;
   logic             q_push;
   logic             q_pop;

   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;
   assign q_push = accept && (bundle.count != 3'd0);

   tbpd_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_rx_byte),
      .bundle(bundle)
   );

   tbpd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(bundle),
      .pop(q_pop),
      .head(head),
      .status(q_status)
   );

   tbpd_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .status(q_status),
      .pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_packet_kind(rsp_packet_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_last_byte(rsp_last_byte),
      .rsp_empty_packet(rsp_empty_packet)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue read while empty");

   a_empty_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_packet) |-> (rsp_last_byte && rsp_payload_byte == 8'd0))
      else $error("empty packet result is not a final zero byte");

endmodule

### rtl/core/tbpd_front.sv
module tbpd_front import tbpd_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output bundle_type bundle
);

   phase_type              phase_ff, phase_in;
   logic [1:0]             match_ff, match_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_valid_ff, held_valid_in;
   logic [1:0]             header_index_ff, header_index_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;

   logic [31:0]            len_word;
   logic [LENGTH_BITS-1:0] len_trunc;
   logic [7:0]             seq [MAX_RESULTS];
   logic [7:0]             chain [MAX_RESULTS];
   logic [2:0]             push_count;

   assign len_word = 32'(remaining_ff) | (32'(rx_byte) << {header_index_ff, 3'b000});
   assign len_trunc = len_word[LENGTH_BITS-1:0];
   assign push_count = 3'(match_ff) + 3'(rx_byte != CHAR_CR);

   always_comb begin
      for (int j = 0; j < MAX_RESULTS; j++) begin
         seq[j] = (2'(j) < match_ff || j == MAX_RESULTS) ? term_pat(2'(j)) : rx_byte;
      end
      seq[MAX_RESULTS-1] = rx_byte;
      chain[0] = held_valid_ff ? held_byte_ff : seq[0];
      for (int j = 1; j < MAX_RESULTS; j++) begin
         chain[j] = held_valid_ff ? seq[j-1] : seq[j];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      held_byte_in = held_byte_ff;
      held_valid_in = held_valid_ff;
      header_index_in = header_index_ff;
      remaining_in = remaining_ff;
      bundle = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == START_BIN) begin
               phase_in = PH_LEN;
               header_index_in = 2'd0;
               remaining_in = '0;
            end else begin
               phase_in = PH_TEXT;
               match_in = 2'd0;
               held_valid_in = 1'b0;
               held_byte_in = 8'd0;
            end
         end
         PH_LEN: begin
            remaining_in = len_trunc;
            header_index_in = header_index_ff + 2'd1;
            if (header_index_ff == 2'd3) begin
               if (len_trunc == '0) begin
                  bundle.count = 3'd1;
                  bundle.res[0] = '{kind: KIND_BIN, data: 8'd0, last: 1'b1, empty: 1'b1};
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_BIN;
               end
            end
         end
         PH_BIN: begin
            remaining_in = remaining_ff - LENGTH_BITS'(1);
            bundle.count = 3'd1;
            bundle.res[0] = '{kind: KIND_BIN, data: rx_byte,
                              last: (remaining_ff == LENGTH_BITS'(1)), empty: 1'b0};
            if (remaining_ff == LENGTH_BITS'(1)) begin
               phase_in = PH_IDLE;
            end
         end
         PH_TEXT: begin
            if (match_ff == 2'd3 && rx_byte == CHAR_LF) begin
               bundle.count = 3'd1;
               bundle.res[0] = '{kind: KIND_TEXT, data: held_byte_ff, last: 1'b1,
                                 empty: !held_valid_ff};
               held_valid_in = 1'b0;
               held_byte_in = 8'd0;
               match_in = 2'd0;
               phase_in = PH_IDLE;
            end else if (rx_byte == term_pat(match_ff)) begin
               match_in = match_ff + 2'd1;
            end else begin
               // The failed prefix and the byte (a CR byte instead starts a new match) go
               // through the hold-back stage; the newest one stays held and the rest are released.
               bundle.count = push_count + 3'(held_valid_ff) - 3'd1;
               for (int j = 0; j < MAX_RESULTS; j++) begin
                  bundle.res[j] = '{kind: KIND_TEXT, data: chain[j], last: 1'b0, empty: 1'b0};
               end
               held_byte_in = seq[2'(push_count - 3'd1)];
               held_valid_in = 1'b1;
               match_in = (rx_byte == CHAR_CR) ? 2'd1 : 2'd0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         match_ff <= 2'd0;
         held_byte_ff <= 8'd0;
         held_valid_ff <= 1'b0;
         header_index_ff <= 2'd0;
         remaining_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         held_byte_ff <= held_byte_in;
         held_valid_ff <= held_valid_in;
         header_index_ff <= header_index_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

### rtl/core/tbpd_queue.sv
module tbpd_queue import tbpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_data,
   input  logic             pop,
   output bundle_type       head,
   output queue_status_type status
);

   bundle_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign status.full = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in = count_ff + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/tbpd_back.sv
module tbpd_back import tbpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       head,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_packet_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last_byte,
   output logic             rsp_empty_packet
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;
   logic [1:0] sub_ff, sub_in;
   logic       load;
   logic       take;

   assign load = !valid_ff || rsp_ready;
   assign take = load && !status.empty;
   assign pop = take && (3'(sub_ff) + 3'd1 == head.count);

   always_comb begin
      valid_in = take ? 1'b1 : (load ? 1'b0 : valid_ff);
      result_in = take ? head.res[sub_ff] : result_ff;
      sub_in = pop ? 2'd0 : (take ? sub_ff + 2'd1 : sub_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_packet_kind = result_ff.kind;
   assign rsp_payload_byte = result_ff.data;
   assign rsp_last_byte = result_ff.last;
   assign rsp_empty_packet = result_ff.empty;

endmodule
